// File: rtl/rlee_pkg.sv
// Shared types, constants and helper functions of the escape-byte RLE encoder.
`timescale 1ns / 1ps
package rlee_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IW = 1;
  localparam logic [CFG_IW-1:0] CFG_ESCAPE = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_MINRUN = 1'b1;

  // Reset values of the registers, the count cap and the escape fill byte
  localparam logic [7:0] ESC_RESET    = 8'hFE;
  localparam logic [7:0] MINRUN_RESET = 8'd3;
  localparam logic [7:0] COUNT_CAP    = 8'd255;
  localparam logic [7:0] ESC_FILL     = 8'h00;

  // Command queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // How one segment of output bytes is formed
  typedef enum logic [1:0] {
    K_NONE,    // nothing
    K_LIT,     // cnt copies of data (cnt is 1..3)
    K_TRIPLE,  // escape, cnt, data
    K_ESC      // escape, 0x00
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] cnt;
  } seg_t;

  // One command: up to two segments, emitted in order
  typedef struct packed {
    seg_t seg0;
    seg_t seg1;
    logic last;   // item closed the stream
  } cmd_t;

  // Classify a run that ends
  function automatic seg_t mk_run(input logic [7:0] data, input logic [7:0] cnt,
                                  input logic [7:0] esc, input logic [2:0] thr);
    seg_t s;
    s.data = data;
    s.cnt  = cnt;
    if (data == esc) begin
      s.kind = (cnt == 8'd1) ? K_ESC : K_TRIPLE;
    end else if (cnt >= {5'd0, thr}) begin
      s.kind = K_TRIPLE;
    end else begin
      s.kind = K_LIT;
    end
    return s;
  endfunction

  // True when idx points at the last byte of a segment
  function automatic logic seg_last(input seg_t s, input logic [1:0] idx);
    logic r;
    case (s.kind)
      K_LIT:    r = (idx == (s.cnt[1:0] - 2'd1));
      K_TRIPLE: r = (idx == 2'd2);
      K_ESC:    r = (idx == 2'd1);
      default:  r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/rle_escape_encoder_top.sv
// Top level of the escape-byte run-length encoder: registers and the two parts.
`timescale 1ns / 1ps
// Takes one raw byte per cycle on the slave stream, tlast marking the final
// byte of a stream. An item that only starts or extends a run is absorbed
// with no output. An item that ends a run goes as a command into a
// four-entry queue; the back part sends its bytes (one to five) at one byte
// per cycle while the output is not stalled, and the input keeps flowing
// until the queue fills. The first output byte caused by an item passes
// through the queue and then the output register. tuser marks the last byte
// caused by an input item, tlast the last byte of the encoded stream.
// Write the escape code and minimum run length only while the block is idle.
module rle_escape_encoder_top import rlee_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // [7:0] in_byte
  input  logic              s_axis_tlast_i,   // stream_end
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [7:0]        m_axis_tdata_o,   // [7:0] out_byte
  output logic              m_axis_tuser_o,   // [0] last_of_item
  output logic              m_axis_tlast_o    // end_of_output
);

  logic [7:0] esc_q, minrun_q;
  logic       q_full, push, pop, head_valid;
  cmd_t       cmd, head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q    <= ESC_RESET;
      minrun_q <= MINRUN_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ESCAPE) begin
        esc_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == CFG_MINRUN) begin
        minrun_q <= cfg_wdata_i;
      end
    end
  end

  rlee_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .esc_i      (esc_q),
    .minrun_i   (minrun_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_end_i   (s_axis_tlast_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  rlee_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  rlee_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .esc_i           (esc_q),
    .head_i          (head),
    .head_valid_i    (head_valid),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_byte_o      (m_axis_tdata_o),
    .out_item_last_o (m_axis_tuser_o),
    .out_end_o       (m_axis_tlast_o)
  );

endmodule

// File: rtl/rlee_front.sv
// Front part: holds the current run and turns each input item into a command.
`timescale 1ns / 1ps
module rlee_front import rlee_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] esc_i,
  input  logic [7:0] minrun_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_end_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [7:0] held_q, held_d;
  logic [7:0] rc_q, rc_d;
  logic [7:0] cnt_inc;
  logic [2:0] thr;
  logic       accept, flush1, is_esc;
  cmd_t       cmd;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  // Threshold held within 2..4
  always_comb begin
    if (minrun_i < 8'd2) begin
      thr = 3'd2;
    end else if (minrun_i > 8'd4) begin
      thr = 3'd4;
    end else begin
      thr = minrun_i[2:0];
    end
  end

  // Classification of the item against the held run
  always_comb begin
    is_esc    = (in_byte_i == esc_i);
    flush1    = (rc_q != 8'd0) && ((in_byte_i != held_q) || is_esc);
    cnt_inc   = rc_q + 8'd1;
    held_d    = held_q;
    rc_d      = rc_q;
    cmd.last  = in_end_i;
    cmd.seg0  = flush1 ? mk_run(held_q, rc_q, esc_i, thr) : seg_t'{K_NONE, 8'd0, 8'd0};
    cmd.seg1  = seg_t'{K_NONE, 8'd0, 8'd0};
    if (is_esc) begin
      cmd.seg1 = seg_t'{K_ESC, esc_i, 8'd1};
      rc_d     = 8'd0;
    end else if ((rc_q != 8'd0) && !flush1) begin
      // same byte extends the run
      if ((cnt_inc == COUNT_CAP) || in_end_i) begin
        cmd.seg1 = mk_run(held_q, cnt_inc, esc_i, thr);
        rc_d     = 8'd0;
      end else begin
        rc_d = cnt_inc;
      end
    end else begin
      // new run starts
      held_d = in_byte_i;
      if (in_end_i) begin
        cmd.seg1 = mk_run(in_byte_i, 8'd1, esc_i, thr);
        rc_d     = 8'd0;
      end else begin
        rc_d = 8'd1;
      end
    end
  end

  // Items that only extend or start a run send nothing down
  assign push_o = accept && ((cmd.seg0.kind != K_NONE) || (cmd.seg1.kind != K_NONE));
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 8'd0;
      rc_q   <= 8'd0;
    end else if (accept) begin
      held_q <= held_d;
      rc_q   <= rc_d;
    end
  end

endmodule

// File: rtl/rlee_fifo.sv
// Short command queue between the front and back parts.
`timescale 1ns / 1ps
module rlee_fifo import rlee_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic head_valid_o
);

  cmd_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QCW-1:0] cnt_q;
  logic           do_pop;

  assign full_o       = (cnt_q == QCW'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_pop       = pop_i & head_valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QAW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QAW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + QCW'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - QCW'(1);
      end
    end
  end

endmodule

// File: rtl/rlee_back.sv
// Back part: walks each command byte by byte into the output register.
`timescale 1ns / 1ps
module rlee_back import rlee_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] esc_i,
  input  cmd_t       head_i,
  input  logic       head_valid_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_item_last_o,
  output logic       out_end_o
);

  logic       seg_q, seg_d;
  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       ilast_q, elast_q;
  logic       on_seg1, seg_done, item_done, advance, fire;
  seg_t       cur;

  // Pick the segment in progress; an empty first segment is skipped
  assign on_seg1 = seg_q | (head_i.seg0.kind == K_NONE);
  assign cur     = on_seg1 ? head_i.seg1 : head_i.seg0;

  // Byte at the current position
  always_comb begin
    case (cur.kind)
      K_LIT:    byte_d = cur.data;
      K_TRIPLE: byte_d = (idx_q == 2'd0) ? esc_i : ((idx_q == 2'd1) ? cur.cnt : cur.data);
      K_ESC:    byte_d = (idx_q == 2'd0) ? esc_i : ESC_FILL;
      default:  byte_d = 8'd0;
    endcase
  end

  assign seg_done  = seg_last(cur, idx_q);
  assign item_done = seg_done & (on_seg1 | (head_i.seg1.kind == K_NONE));
  assign advance   = ~valid_q | out_ready_i;
  assign fire      = advance & head_valid_i;
  assign pop_o     = fire & item_done;
  assign valid_d   = advance ? head_valid_i : valid_q;

  // Position within the command
  always_comb begin
    seg_d = seg_q;
    idx_d = idx_q;
    if (fire) begin
      if (item_done) begin
        seg_d = 1'b0;
        idx_d = 2'd0;
      end else if (seg_done) begin
        seg_d = 1'b1;
        idx_d = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= 1'b0;
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      seg_q   <= seg_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q  <= byte_d;
      ilast_q <= item_done;
      elast_q <= item_done & head_i.last;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign out_item_last_o = ilast_q;
  assign out_end_o       = elast_q;

endmodule

// File: rtl/rlee_checker.sv
// Port-level checks of the encoder, bound to the top level.
`timescale 1ns / 1ps
module rlee_checker import rlee_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic              s_axis_tlast_i,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [7:0]        m_axis_tdata_o,
  input logic              m_axis_tuser_o,
  input logic              m_axis_tlast_o
);

  logic [3:0] pend_q;
  logic       in_end_acc, out_end_acc;

  assign in_end_acc  = s_axis_tvalid_i & s_axis_tready_o & s_axis_tlast_i;
  assign out_end_acc = m_axis_tvalid_o & m_axis_tready_i & m_axis_tlast_o;

  // Streams closed at the input but not yet at the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 4'd0;
    end else if (in_end_acc && !out_end_acc) begin
      pend_q <= pend_q + 4'd1;
    end else if (!in_end_acc && out_end_acc) begin
      pend_q <= pend_q - 4'd1;
    end
  end

  // A stalled output byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output byte changed while stalled");

  // The end of the stream is always the last byte of its item
  a_end_is_item_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("stream end not on last byte of item");

  // No stream end leaves without a stream end taken in
  a_end_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_end_acc |-> pend_q != 4'd0)
    else $error("stream end sent without a closing input item");

  // Nothing is offered on the first edge after reset
  a_quiet_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid right after reset");

endmodule

bind rle_escape_encoder_top rlee_checker u_rlee_checker (.*);

// File: verif/rle_escape_encoder_top_tb.sv
// Self-checking testbench of the escape-byte run-length encoder top level.
`timescale 1ns / 1ps
module rle_escape_encoder_top_tb;
  import rlee_pkg::*;

  // One encoded output byte with its markers
  typedef struct packed {
    logic [7:0] data;
    logic       item_end;
    logic       stream_end;
  } enc_byte_t;

  // One raw input item
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } raw_byte_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_idx = CFG_ESCAPE;
  logic [7:0]        cfg_wdata = 8'h00;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_data = 8'h00;
  logic              in_fin = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_data;
  logic              out_item_end;
  logic              out_stream_end;

  rle_escape_encoder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tlast_i  (in_fin),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_item_end),
    .m_axis_tlast_o  (out_stream_end)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Encoder state mirrored by the predictor
  logic [7:0] esc_code = ESC_RESET;
  logic [7:0] min_run  = MINRUN_RESET;
  logic [7:0] run_byte = 8'h00;
  logic [7:0] run_len  = 8'h00;

  raw_byte_t pending_bytes[$];
  enc_byte_t expected_bytes[$];
  enc_byte_t burst_bytes[$];
  int        items_queued = 0;
  int        items_taken = 0;
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  function automatic void put_byte(input logic [7:0] b);
    burst_bytes.insert(burst_bytes.size(),
                       enc_byte_t'{data: b, item_end: 1'b0, stream_end: 1'b0});
  endfunction

  // Send out the held run, if any
  function automatic void close_run();
    logic [7:0] thr;
    if (run_len == 8'd0) return;
    thr = min_run;
    if (thr < 8'd2) thr = 8'd2;
    if (thr > 8'd4) thr = 8'd4;
    if (run_byte == esc_code && run_len == 8'd1) begin
      put_byte(esc_code);
      put_byte(ESC_FILL);
    end else if (run_byte == esc_code || run_len >= thr) begin
      put_byte(esc_code);
      put_byte(run_len);
      put_byte(run_byte);
    end else begin
      for (int k = 0; k < run_len; k++) put_byte(run_byte);
    end
    run_len = 8'd0;
  endfunction

  // Predict the bytes caused by one accepted item
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    burst_bytes.delete();
    if (run_len != 8'd0 && (b != run_byte || b == esc_code)) close_run();
    if (b == esc_code) begin
      put_byte(esc_code);
      put_byte(ESC_FILL);
    end else if (run_len != 8'd0) begin
      run_len = run_len + 8'd1;
      if (run_len >= COUNT_CAP) close_run();
    end else begin
      run_byte = b;
      run_len = 8'd1;
    end
    if (fin) close_run();
    if (burst_bytes.size() > 0) begin
      burst_bytes[burst_bytes.size() - 1].item_end = 1'b1;
      burst_bytes[burst_bytes.size() - 1].stream_end = fin;
    end
    foreach (burst_bytes[i]) expected_bytes.insert(expected_bytes.size(), burst_bytes[i]);
  endfunction

  // Input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_bytes[0].data;
        in_fin <= pending_bytes[0].fin;
        void'(pending_bytes.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output backpressure
  always @(posedge clk_i) begin
    out_ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void note_mismatch(input enc_byte_t want, input enc_byte_t got);
    errors++;
    if (errors <= 10)
      $display("mismatch: expected byte %02h item_end %0b stream_end %0b, got %02h %0b %0b",
               want.data, want.item_end, want.stream_end,
               got.data, got.item_end, got.stream_end);
  endfunction

  // Monitor: predict on input acceptance, then check output
  always @(posedge clk_i) begin
    enc_byte_t got;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        encode_byte(in_data, in_fin);
        items_taken++;
      end
      if (out_valid && out_ready) begin
        got = '{data: out_data, item_end: out_item_end, stream_end: out_stream_end};
        if (expected_bytes.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected output byte %02h item_end %0b stream_end %0b",
                     got.data, got.item_end, got.stream_end);
        end else if (expected_bytes[0] != got) begin
          note_mismatch(expected_bytes[0], got);
          void'(expected_bytes.pop_front());
        end else begin
          void'(expected_bytes.pop_front());
        end
      end
    end
  end

  task automatic push_item(input logic [7:0] b, input logic fin);
    pending_bytes.insert(pending_bytes.size(), raw_byte_t'{data: b, fin: fin});
    items_queued++;
  endtask

  // Wait until every item is taken and every byte has come out
  task automatic wait_drained();
    while (items_taken != items_queued || expected_bytes.size() != 0) @(negedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IW-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ESCAPE: esc_code = val;
      CFG_MINRUN: min_run = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Random runs with random content; stream ends fall anywhere
  task automatic queue_random(input int n_items);
    int left;
    int len;
    logic [7:0] b;
    left = n_items;
    while (left > 0) begin
      case ($urandom_range(9))
        0, 1: b = esc_code;
        2: b = esc_code + 8'd1;
        3: b = 8'h00;
        4: b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      len = ($urandom_range(15) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 5);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) push_item(b, $urandom_range(11) == 0);
      left -= len;
    end
  endtask

  initial begin
    logic [7:0] esc_set[6];
    logic [7:0] minrun_set[6];
    esc_set = '{8'h00, 8'hFF, 8'h41, 8'($urandom), 8'($urandom), ESC_RESET};
    minrun_set = '{8'd1, 8'd255, 8'd2, 8'd4, 8'($urandom_range(1, 255)), MINRUN_RESET};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 36;
    recv_stall_pct = 77;

    // Directed: single literal, short run, triple, escape byte, run broken by escape
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b0);
    push_item(8'hFF, 1'b1);
    repeat (3) push_item(8'h55, 1'b0);
    push_item(8'h55, 1'b1);
    push_item(ESC_RESET, 1'b1);
    push_item(8'hAA, 1'b0);
    push_item(8'hAA, 1'b0);
    push_item(ESC_RESET, 1'b0);
    push_item(8'hAA, 1'b1);
    push_item(8'h12, 1'b0);
    push_item(8'h34, 1'b1);
    repeat (4) push_item(8'h80, 1'b0);
    push_item(8'h01, 1'b1);
    wait_drained();

    // Escape code moved onto a held run of one byte, then of two
    push_item(8'h41, 1'b0);
    wait_drained();
    write_cfg(CFG_ESCAPE, 8'h41);
    push_item(8'h42, 1'b1);
    wait_drained();
    write_cfg(CFG_ESCAPE, 8'h50);
    push_item(8'h41, 1'b0);
    push_item(8'h41, 1'b0);
    wait_drained();
    write_cfg(CFG_ESCAPE, 8'h41);
    push_item(8'h41, 1'b1);
    wait_drained();

    // Random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 36 : (p < 4) ? 77 : 0;
      recv_stall_pct = (p < 2) ? 77 : (p < 4) ? 36 : 0;
      write_cfg(CFG_ESCAPE, esc_set[p]);
      write_cfg(CFG_MINRUN, minrun_set[p]);
      // one run long enough to hit the count cap
      if (p == 2)
        for (int k = 0; k < 260; k++) push_item(8'h33, k == 259);
      queue_random(24);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
